// ===== sv/dslk_pkg.sv =====
// shared types and constants for the distance stability lock
`default_nettype none
package dslk_pkg;

    localparam int CM_W     = 9;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 5;
    localparam int IDX_W    = 8;
    localparam int CFG_W    = 32;
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    localparam logic [CM_W-1:0] MAX_RANGE_CM = 9'd500;

    localparam logic [IDX_W-1:0] REG_TOLERANCE = 8'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW    = 8'd1;
    localparam logic [IDX_W-1:0] REG_SETTLE    = 8'd2;
    localparam logic [IDX_W-1:0] REG_UNLOCK    = 8'd3;

    localparam logic [CM_W-1:0]   TOLERANCE_RST = 9'd2;
    localparam logic [WIN_W-1:0]  WINDOW_RST    = 5'd5;
    localparam logic [TIME_W-1:0] SETTLE_RST    = 32'd1000;
    localparam logic [CM_W-1:0]   UNLOCK_RST    = 9'd10;

    typedef enum logic {
        ALU_ABS,
        ALU_WRAP
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] limit;
    } alu_req_t;

endpackage
`default_nettype wire

// ===== sv/distance_stability_lock_core.sv =====
// distance stability lock: top level with sequencer, config registers and output register
//
// s_ channel carries one ultrasonic sample per transfer: distance in cm (0 = no echo)
// and a millisecond time stamp in tdata, a lock clear request in tuser.
// m_ channel returns one result per sample: output distance, substituted current
// distance, lock and stability flags.
// cfg channel writes one register per transfer (index 0..3); ready is always high.
// the user is to make writes only while no sample is in flight; the core does not
// enforce this. a window write clears the ring. after accept a sample passes through the
// substitute, ring read, base, scan, unlock, optional timer and output states; the ring
// slots in use are scanned one slot per cycle through the ring's single registered read
// port and one shared compare unit, and the scan stops at the first slot out of tolerance.
// the next sample can be taken in the cycle after the result is loaded.
// s_tready is high only while the sequencer is idle; a new sample is taken while
// the previous result still waits in the output register.
// if the receiver stalls, the next result waits inside the core until m_tready.
// reset clears the ring, the write slot, the lock and timer state and loads the
// register defaults: tolerance 2, window 5, settle 1000 ms, unlock threshold 10.
`default_nettype none
module distance_stability_lock_core #(
    parameter int MAX_SLOTS    = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample_cm[8:0], now_ms[40:9], zero pad
    input  wire logic [dslk_pkg::S_DATA_W-1:0] s_tdata,
    // clear_lock[0]
    input  wire logic [dslk_pkg::S_USER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // distance_cm[8:0], current_cm[17:9], zero pad
    output logic      [dslk_pkg::M_DATA_W-1:0] m_tdata,
    // is_locked[0], is_stable[1]
    output logic      [dslk_pkg::M_USER_W-1:0] m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dslk_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [dslk_pkg::CFG_W-1:0]    cfg_data
);

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = dslk_pkg::CM_W;
    localparam int TW = dslk_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_RD0,
        S_BASE,
        S_SCAN,
        S_UNL,
        S_TMR,
        S_OUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   tol_reg;
    logic [dslk_pkg::WIN_W-1:0] win_reg;
    logic [TW-1:0]   settle_reg;
    logic [CW-1:0]   thr_reg;

    logic [SW-1:0]   ws_reg;
    logic [SW-1:0]   scan_reg;
    logic [CW-1:0]   cur_reg;
    logic [CW-1:0]   base_reg;
    logic [TW-1:0]   now_reg;
    logic            stable_reg;
    logic            lock_reg;
    logic [CW-1:0]   held_reg;
    logic            timing_reg;
    logic [TW-1:0]   start_reg;

    logic            m_valid_reg;
    logic [CW-1:0]   m_dist_reg;
    logic [CW-1:0]   m_cur_reg;
    logic            m_lock_reg;
    logic            m_stable_reg;

    logic [31:0]     n_ext;
    logic [SW-1:0]   last_slot;
    logic [SW-1:0]   ws_eff;
    logic [SW-1:0]   prev_slot;
    logic [CW-1:0]   in_cm;
    logic [CW-1:0]   in_sat;
    logic [CW-1:0]   cur_sub;
    logic            s_fire;
    logic            cfg_fire;
    logic            ring_clear;
    logic            ring_wr;
    logic [SW-1:0]   ring_raddr;
    logic [CW-1:0]   ring_rdata;
    dslk_pkg::alu_req_t alu_req;
    logic            alu_gt;

    always_comb begin
        if (win_reg == '0) begin
            n_ext = 32'd1;
        end else if (32'(win_reg) > MAX_SLOTS) begin
            n_ext = 32'(MAX_SLOTS);
        end else begin
            n_ext = 32'(win_reg);
        end
    end

    assign last_slot = SW'(n_ext - 32'd1);
    assign ws_eff    = (ws_reg > last_slot) ? '0 : ws_reg;
    assign prev_slot = (ws_eff == '0) ? last_slot : ws_eff - SW'(1);

    assign in_cm  = s_tdata[CW-1:0];
    assign in_sat = (in_cm > dslk_pkg::MAX_RANGE_CM) ? dslk_pkg::MAX_RANGE_CM : in_cm;
    assign cur_sub = (cur_reg == '0) ? ring_rdata : cur_reg;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign ring_clear = cfg_fire && (cfg_index == dslk_pkg::REG_WINDOW);
    assign ring_wr    = (state_reg == S_SUB);

    always_comb begin
        unique case (state_reg)
            S_IDLE:  ring_raddr = prev_slot;
            S_BASE:  ring_raddr = SW'(1);
            S_SCAN:  ring_raddr = scan_reg + SW'(1);
            default: ring_raddr = '0;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_TMR: begin
                alu_req.op    = dslk_pkg::ALU_WRAP;
                alu_req.a     = now_reg;
                alu_req.b     = start_reg;
                alu_req.limit = settle_reg;
            end
            S_UNL: begin
                alu_req.op    = dslk_pkg::ALU_ABS;
                alu_req.a     = TW'(cur_reg);
                alu_req.b     = TW'(held_reg);
                alu_req.limit = TW'(thr_reg);
            end
            default: begin
                alu_req.op    = dslk_pkg::ALU_ABS;
                alu_req.a     = TW'(ring_rdata);
                alu_req.b     = TW'(base_reg);
                alu_req.limit = TW'(tol_reg);
            end
        endcase
    end

    dslk_ring #(
        .DEPTH (MAX_SLOTS),
        .AW    (SW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (ring_clear),
        .wr_en   (ring_wr),
        .waddr   (ws_reg),
        .wdata   (cur_sub),
        .raddr   (ring_raddr),
        .rdata   (ring_rdata)
    );

    dslk_alu u_alu (
        .req (alu_req),
        .gt  (alu_gt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= dslk_pkg::TOLERANCE_RST;
            win_reg    <= dslk_pkg::WINDOW_RST;
            settle_reg <= dslk_pkg::SETTLE_RST;
            thr_reg    <= dslk_pkg::UNLOCK_RST;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                dslk_pkg::REG_TOLERANCE: tol_reg    <= cfg_data[CW-1:0];
                dslk_pkg::REG_WINDOW:    win_reg    <= cfg_data[dslk_pkg::WIN_W-1:0];
                dslk_pkg::REG_SETTLE:    settle_reg <= cfg_data[TW-1:0];
                dslk_pkg::REG_UNLOCK:    thr_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ws_reg      <= '0;
            scan_reg    <= '0;
            stable_reg  <= 1'b1;
            lock_reg    <= 1'b0;
            held_reg    <= '0;
            timing_reg  <= 1'b0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_OUT) && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cur_reg <= in_sat;
                        now_reg <= s_tdata[CW +: TW];
                        ws_reg  <= ws_eff;
                        if (s_tuser[0]) begin
                            lock_reg   <= 1'b0;
                            held_reg   <= '0;
                            timing_reg <= 1'b0;
                        end
                        state_reg <= S_SUB;
                    end else if (ring_clear) begin
                        ws_reg <= '0;
                    end
                end
                S_SUB: begin
                    cur_reg   <= cur_sub;
                    ws_reg    <= (ws_reg == last_slot) ? '0 : ws_reg + SW'(1);
                    state_reg <= S_RD0;
                end
                S_RD0: begin
                    state_reg <= S_BASE;
                end
                S_BASE: begin
                    base_reg   <= ring_rdata;
                    scan_reg   <= SW'(1);
                    stable_reg <= 1'b1;
                    state_reg  <= (last_slot == '0) ? S_UNL : S_SCAN;
                end
                S_SCAN: begin
                    if (alu_gt) begin
                        stable_reg <= 1'b0;
                        state_reg  <= S_UNL;
                    end else if (scan_reg == last_slot) begin
                        state_reg <= S_UNL;
                    end else begin
                        scan_reg <= scan_reg + SW'(1);
                    end
                end
                S_UNL: begin
                    priority if (lock_reg && alu_gt) begin
                        lock_reg   <= 1'b0;
                        held_reg   <= '0;
                        timing_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else if (stable_reg && !lock_reg) begin
                        if (!timing_reg) begin
                            timing_reg <= 1'b1;
                            start_reg  <= now_reg;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_TMR;
                        end
                    end else if (!stable_reg) begin
                        timing_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_TMR: begin
                    if (alu_gt) begin
                        lock_reg <= 1'b1;
                        held_reg <= cur_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_dist_reg   <= lock_reg ? held_reg : cur_reg;
                        m_cur_reg    <= cur_reg;
                        m_lock_reg   <= lock_reg;
                        m_stable_reg <= stable_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dslk_pkg::M_DATA_W - 2 * CW){1'b0}}, m_cur_reg, m_dist_reg};
    assign m_tuser  = {m_stable_reg, m_lock_reg};

endmodule
`default_nettype wire

// ===== sv/dslk_ring.sv =====
// sample ring memory with per-slot valid bits, invalid slots read as zero
`default_nettype none
module dslk_ring #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [dslk_pkg::CM_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [dslk_pkg::CM_W-1:0] rdata
);

    logic [dslk_pkg::CM_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]          valid_reg;
    logic [dslk_pkg::CM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (valid_reg[raddr]) begin
            rdata_reg <= mem[raddr];
        end else begin
            rdata_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/dslk_alu.sv =====
// shared difference and compare unit: |a-b| or wrapped a-b against a limit
`default_nettype none
module dslk_alu (
    input  wire dslk_pkg::alu_req_t req,
    output logic                    gt
);

    logic [dslk_pkg::TIME_W-1:0] diff;

    always_comb begin
        unique case (req.op)
            dslk_pkg::ALU_ABS:  diff = (req.a > req.b) ? (req.a - req.b) : (req.b - req.a);
            dslk_pkg::ALU_WRAP: diff = req.a - req.b;
            default:            diff = req.a - req.b;
        endcase
        gt = diff > req.limit;
    end

endmodule
`default_nettype wire

// ===== tb/dslk_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the distance stability lock: predicts each sample's result and compares
module dslk_result_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [dslk_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [dslk_pkg::S_USER_W-1:0]  s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [dslk_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic [dslk_pkg::M_USER_W-1:0]  m_tuser,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [dslk_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [dslk_pkg::CFG_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  results_owed
);

    localparam int CW = dslk_pkg::CM_W;
    localparam int TW = dslk_pkg::TIME_W;
    localparam int SLOT_COUNT = 16;
    localparam logic [CW-1:0] RANGE_TOP_CM = 9'd500;

    typedef struct packed {
        logic [CW-1:0] distance_cm;
        logic [CW-1:0] current_cm;
        logic          is_locked;
        logic          is_stable;
    } lock_result_t;

    logic [CW-1:0]               tolerance_cm;
    logic [dslk_pkg::WIN_W-1:0]  window_len;
    logic [TW-1:0]               settle_ms;
    logic [CW-1:0]               unlock_cm;
    logic [CW-1:0]               ring_cm [SLOT_COUNT];
    logic [3:0]                  next_slot;
    logic                        locked;
    logic [CW-1:0]               held_cm;
    logic                        timer_on;
    logic [TW-1:0]               timer_start_ms;
    lock_result_t                owed_q [$];

    function automatic logic [CW-1:0] cm_gap(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic clear_ring();
        foreach (ring_cm[i]) ring_cm[i] = '0;
        next_slot = '0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic predict_sample(input logic [CW-1:0] raw_cm, input logic [TW-1:0] now_ms,
                                  input logic clr, output lock_result_t res);
        int n;
        int prev;
        logic [CW-1:0] cur;
        logic stable;
        logic [TW-1:0] elapsed;
        n = (window_len == 0) ? 1 : ((window_len > SLOT_COUNT) ? SLOT_COUNT : int'(window_len));
        if (clr) begin
            locked = 1'b0;
            held_cm = '0;
            timer_on = 1'b0;
        end
        cur = (raw_cm > RANGE_TOP_CM) ? RANGE_TOP_CM : raw_cm;
        if (next_slot >= n) next_slot = '0;
        prev = (next_slot != 0) ? int'(next_slot) - 1 : n - 1;
        if (cur == '0) cur = ring_cm[prev];
        ring_cm[next_slot] = cur;
        next_slot = 4'((int'(next_slot) + 1) % n);
        stable = 1'b1;
        for (int i = 1; i < n; i++) begin
            if (cm_gap(ring_cm[i], ring_cm[0]) > tolerance_cm) stable = 1'b0;
        end
        if (locked && cm_gap(cur, held_cm) > unlock_cm) begin
            locked = 1'b0;
            held_cm = '0;
            timer_on = 1'b0;
        end else if (stable && !locked) begin
            if (!timer_on) begin
                timer_on = 1'b1;
                timer_start_ms = now_ms;
            end else begin
                elapsed = now_ms - timer_start_ms;
                if (elapsed > settle_ms) begin
                    locked = 1'b1;
                    held_cm = cur;
                end
            end
        end else if (!stable) begin
            timer_on = 1'b0;
        end
        res.distance_cm = locked ? held_cm : cur;
        res.current_cm  = cur;
        res.is_locked   = locked;
        res.is_stable   = stable;
    endtask

    always @(posedge aclk) begin : watch
        lock_result_t want;
        lock_result_t got;
        if (!aresetn) begin
            tolerance_cm = dslk_pkg::TOLERANCE_RST;
            window_len = dslk_pkg::WINDOW_RST;
            settle_ms = dslk_pkg::SETTLE_RST;
            unlock_cm = dslk_pkg::UNLOCK_RST;
            clear_ring();
            locked = 1'b0;
            held_cm = '0;
            timer_on = 1'b0;
            timer_start_ms = '0;
            owed_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dslk_pkg::REG_TOLERANCE: tolerance_cm = cfg_data[CW-1:0];
                    dslk_pkg::REG_WINDOW: begin
                        window_len = cfg_data[dslk_pkg::WIN_W-1:0];
                        clear_ring();
                    end
                    dslk_pkg::REG_SETTLE: settle_ms = cfg_data[TW-1:0];
                    dslk_pkg::REG_UNLOCK: unlock_cm = cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.distance_cm = m_tdata[CW-1:0];
                got.current_cm  = m_tdata[2*CW-1:CW];
                got.is_locked   = m_tuser[0];
                got.is_stable   = m_tuser[1];
                if (owed_q.size() == 0) begin
                    report_mismatch("result with none owed", m_tdata, 0);
                end else begin
                    want = owed_q.pop_front();
                    if (got.distance_cm != want.distance_cm)
                        report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
                    if (got.current_cm != want.current_cm)
                        report_mismatch("current_cm", got.current_cm, want.current_cm);
                    if (got.is_locked != want.is_locked)
                        report_mismatch("is_locked", got.is_locked, want.is_locked);
                    if (got.is_stable != want.is_stable)
                        report_mismatch("is_stable", got.is_stable, want.is_stable);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata[CW-1:0], s_tdata[CW+TW-1:CW], s_tuser[0], want);
                owed_q.push_back(want);
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the distance stability lock: clock, reset, stimulus and verdict
module tb;

    localparam int CW = dslk_pkg::CM_W;
    localparam int TW = dslk_pkg::TIME_W;
    localparam logic [dslk_pkg::IDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [dslk_pkg::IDX_W-1:0] REG_SPARE_HI = 8'hFF;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_CHUNKS = 8;
    localparam int CHUNK_ITEMS   = 104;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [dslk_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic [dslk_pkg::S_USER_W-1:0] s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [dslk_pkg::M_DATA_W-1:0] m_tdata;
    logic [dslk_pkg::M_USER_W-1:0] m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dslk_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [dslk_pkg::CFG_W-1:0]    cfg_data  = '0;

    int fail_count;
    int results_owed;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int tol_now        = 2;
    int step_ms_max    = 300;
    int base_cm        = 200;
    logic [TW-1:0] clock_ms = 32'hFFFF_0000;

    distance_stability_lock_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dslk_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input logic [dslk_pkg::IDX_W-1:0] idx,
                             input logic [dslk_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [CW-1:0] cm, input logic [TW-1:0] ms,
                               input logic clr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dslk_pkg::S_DATA_W-CW-TW){1'b0}}, ms, cm};
        s_tuser  <= clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_results(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_config(input int tol, input int win, input int settle, input int unlock);
        write_reg(dslk_pkg::REG_TOLERANCE, tol);
        write_reg(dslk_pkg::REG_WINDOW, win);
        write_reg(dslk_pkg::REG_SETTLE, settle);
        write_reg(dslk_pkg::REG_UNLOCK, unlock);
        tol_now = tol;
        step_ms_max = settle / 3 + 1;
    endtask

    task automatic send_random_item();
        int pick;
        int v;
        logic clr;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 6) base_cm = $urandom_range(1, 500);
        if (pick < 72) begin
            v = base_cm + $urandom_range(0, tol_now);
            if (v > 500) v = 500;
        end else if (pick < 82) begin
            v = 0;
        end else if (pick < 90) begin
            v = $urandom_range(0, 511);
        end else begin
            v = $urandom_range(1, 500);
        end
        if ($urandom_range(99) < 3) begin
            clock_ms = $urandom();
        end else begin
            clock_ms = clock_ms + $urandom_range(0, step_ms_max);
        end
        clr = ($urandom_range(99) < 4);
        send_sample(9'(v), clock_ms, clr);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: timer started at time zero, lock at zero, unlock, clear
        send_sample(9'd0, 32'd0, 1'b0);
        send_sample(9'd0, 32'd500, 1'b0);
        send_sample(9'd0, 32'd1001, 1'b0);
        send_sample(9'd50, 32'd1002, 1'b0);
        send_sample(9'd120, 32'd2000, 1'b1);
        wait_results(DRAIN_CYCLES);

        // window of zero, widest tolerance, zero settle time and unlock threshold
        write_reg(dslk_pkg::REG_WINDOW, 32'hFFFF_FFE0);
        write_reg(dslk_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(dslk_pkg::REG_SETTLE, 32'd0);
        write_reg(dslk_pkg::REG_UNLOCK, 32'hFFFF_FE00);
        write_reg(REG_SPARE_LO, 32'h0000_0123);
        send_sample(9'd511, 32'd5, 1'b0);
        send_sample(9'd300, 32'd5, 1'b0);
        send_sample(9'd300, 32'd6, 1'b0);
        send_sample(9'd300, 32'd7, 1'b0);
        send_sample(9'd301, 32'd8, 1'b0);
        send_sample(9'd0, 32'd9, 1'b0);
        send_sample(9'd256, 32'd10, 1'b1);
        wait_results(DRAIN_CYCLES);

        // window above the store, zero tolerance, longest settle time
        write_reg(dslk_pkg::REG_WINDOW, 32'd31);
        write_reg(dslk_pkg::REG_TOLERANCE, 32'd0);
        write_reg(dslk_pkg::REG_SETTLE, 32'hFFFF_FFFF);
        write_reg(dslk_pkg::REG_UNLOCK, 32'd500);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_sample(9'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(9'd511, 32'd0, 1'b0);
        send_sample(9'd1, 32'h8000_0000, 1'b0);
        send_sample(9'd170, 32'h5555_5555, 1'b0);
        send_sample(9'd341, 32'hAAAA_AAAA, 1'b0);
        wait_results(DRAIN_CYCLES);

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            unique case (chunk / 2)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            unique case (chunk)
                0: set_config(0, 16, 0, 0);
                1: set_config(500, 1, 2000, 500);
                default: set_config($urandom_range(0, 12), $urandom_range(0, 31),
                                    $urandom_range(0, 1500), $urandom_range(0, 40));
            endcase
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                if (k == CHUNK_ITEMS / 2) wait_results(0);
                send_random_item();
            end
            wait_results(DRAIN_CYCLES);
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dslk_pkg.sv
sv/dslk_ring.sv
sv/dslk_alu.sv
sv/distance_stability_lock_core.sv
tb/dslk_result_checker.sv
tb/tb.sv
